FILE: design/ucb_pkg.sv
// shared types and constants for the unique color table builder
package ucb_pkg;

  localparam int unsigned ColorWidth = 24;
  localparam int unsigned SlotWidth  = 8;
  localparam int unsigned CountWidth = 9;
  localparam int unsigned MaxSlots   = 256;

  typedef struct packed {
    logic       start_of_image;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } ucb_pixel_t;

  typedef struct packed {
    logic [SlotWidth-1:0]  color_index;
    logic                  is_new;
    logic                  dropped;
    logic [CountWidth-1:0] entry_count;
  } ucb_result_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic                  busy;
    logic [ColorWidth-1:0] color;
    logic                  hit;
    logic                  fresh;
    logic [SlotWidth-1:0]  slot;
  } ucb_token_t;

  typedef enum logic {
    UCB_IDLE,
    UCB_SEARCH
  } ucb_state_t;

endpackage

FILE: design/unique_color_table_builder.sv
// top level: table of distinct colors kept in a chain of compare cells
// an accepted item passes the head register, one compare cell per slot (TABLE_DEPTH,
// clamped to 256) and the output register; new items stall until its token exits
// an item is accepted while a result waits in the output register, not the holding slot
// reset clears the entry count and all control; stored colors are not cleared
module unique_color_table_builder
  import ucb_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  ucb_pixel_t  pixel,
  output logic        result_valid,
  input  logic        result_stall,
  output ucb_result_t result
);

  localparam int unsigned Capacity = (TABLE_DEPTH < MaxSlots) ? TABLE_DEPTH : MaxSlots;

  ucb_state_t            state;
  ucb_state_t            state_next;
  logic [CountWidth-1:0] count;
  logic [CountWidth-1:0] count_next;
  ucb_token_t            chain [Capacity+1];
  ucb_token_t            tail;
  ucb_result_t           finished;
  ucb_result_t           pend;
  logic                  pend_valid;
  logic                  accept;
  logic                  done;
  logic                  out_free;

  assign accept   = pixel_valid && !pixel_stall;
  assign tail     = chain[Capacity];
  assign done     = tail.busy;
  assign out_free = !result_valid || !result_stall;

  // head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].busy <= 1'b0;
    end else begin
      chain[0].busy <= accept;
    end
    chain[0].color <= {pixel.red, pixel.green, pixel.blue};
    chain[0].hit   <= 1'b0;
    chain[0].fresh <= 1'b0;
    chain[0].slot  <= '0;
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    ucb_cell #(
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .count    (count),
      .token_in (chain[i]),
      .token_out(chain[i+1])
    );
  end

  always_comb begin
    finished.color_index = tail.hit ? tail.slot : '0;
    finished.is_new      = tail.fresh;
    finished.dropped     = !tail.hit;
    finished.entry_count = count + CountWidth'(tail.fresh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= UCB_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    pixel_stall = 1'b1;
    case (state)
      UCB_IDLE: begin
        pixel_stall = pend_valid;
        if (accept) begin
          state_next = UCB_SEARCH;
          if (pixel.start_of_image) begin
            count_next = '0;
          end
        end
      end
      UCB_SEARCH: begin
        if (done) begin
          state_next = UCB_IDLE;
          count_next = finished.entry_count;
        end
      end
      default: begin
        state_next = UCB_IDLE;
      end
    endcase
  end

  // output register with one holding slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else if (out_free) begin
      if (pend_valid) begin
        result_valid <= 1'b1;
        pend_valid   <= 1'b0;
      end else begin
        result_valid <= done;
      end
    end else if (done) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid) begin
        result <= pend;
      end else if (done) begin
        result <= finished;
      end
    end else if (done) begin
      pend <= finished;
    end
  end

endmodule

FILE: design/ucb_cell.sv
// one table slot: holds a color, compares the passing token and appends on the free slot
module ucb_cell
  import ucb_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CountWidth-1:0] count,
  input  ucb_token_t            token_in,
  output ucb_token_t            token_out
);

  localparam logic [CountWidth-1:0] IndexCount = CountWidth'(INDEX);
  localparam logic [SlotWidth-1:0]  IndexSlot  = SlotWidth'(INDEX);

  logic [ColorWidth-1:0] stored;
  logic                  searching;
  logic                  match;
  logic                  append;

  assign searching = token_in.busy && !token_in.hit;
  assign match     = searching && (IndexCount < count) && (stored == token_in.color);
  assign append    = searching && (IndexCount == count);

  always_ff @(posedge clk) begin
    if (append) begin
      stored <= token_in.color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_out.busy <= 1'b0;
    end else begin
      token_out.busy <= token_in.busy;
    end
    token_out.color <= token_in.color;
    token_out.hit   <= token_in.hit | match | append;
    token_out.fresh <= token_in.fresh | append;
    token_out.slot  <= (match || append) ? IndexSlot : token_in.slot;
  end

endmodule

FILE: design/ucb_checker.sv
// port checker for the unique color table builder, bound to the top level
module ucb_checker
  import ucb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        pixel_valid,
  input logic        pixel_stall,
  input ucb_pixel_t  pixel,
  input logic        result_valid,
  input logic        result_stall,
  input ucb_result_t result
);

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_dropped_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.dropped |->
      !result.is_new && (result.color_index == '0) && (result.entry_count != '0))
    else $error("dropped item with bad fields");

  // a new color lands in the last slot
  a_new_slot: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_new |->
      ({1'b0, result.color_index} == (result.entry_count - 9'd1)) && !result.dropped)
    else $error("new color not in last slot");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_new && !result.dropped |->
      ({1'b0, result.color_index} < result.entry_count))
    else $error("hit slot beyond entry count");

endmodule

bind unique_color_table_builder ucb_checker u_ucb_checker (.*);
